/* hdl/dcl_pkg.sv */
// ----------------------------------------------------------------------------
// Duty cycle limiter package
// Shared word types, configuration constants and register indexes.
// ----------------------------------------------------------------------------
package dcl_pkg;

  // Width of the window and budget values in milliseconds (at most 3,600,000).
  localparam int unsigned MsW = 22;

  localparam logic [15:0] WinSecMin   = 16'd10;
  localparam logic [15:0] WinSecMax   = 16'd3600;
  localparam logic [15:0] WinSecReset = 16'd600;
  localparam logic [9:0]  PermMin     = 10'd1;
  localparam logic [9:0]  PermMax     = 10'd1000;
  localparam logic [9:0]  PermReset   = 10'd100;
  localparam logic [9:0]  MsPerSec    = 10'd1000;

  localparam logic [MsW-1:0] WindowMsReset = 22'd600000;
  localparam logic [MsW-1:0] BudgetMsReset = 22'd60000;

  // Register indexes, taken from paddr[2].
  localparam logic RegWindowSeconds = 1'b0;
  localparam logic RegPermille      = 1'b1;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        tx_busy;
  } dcl_in_t;

  typedef struct packed {
    logic        tx_allowed;
    logic        new_window;
    logic [31:0] used_ms;
  } dcl_out_t;

  typedef struct packed {
    logic [MsW-1:0] window_ms;
    logic [MsW-1:0] budget_ms;
  } dcl_cfg_t;

endpackage

/* hdl/tx_duty_cycle_limiter.sv */
// ----------------------------------------------------------------------------
// Transmit duty cycle limiter
// Tracks transmitter busy time per window and flags when the budget is spent.
// ----------------------------------------------------------------------------
// Each input word (timestamp and busy level) gives exactly one output word.
// A word is taken into an input register, processed by the combinational core
// update, and held in an output register, so a new word is accepted every
// clock while downstream keeps up. An output word is valid once it has moved
// from the input register into the output register. A configuration write
// first updates the seconds and permille registers; the window and budget
// registers are then updated from them.
module tx_duty_cycle_limiter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dcl_pkg::dcl_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dcl_pkg::dcl_out_t out_word_o
);

  dcl_pkg::dcl_cfg_t cfg;
  dcl_pkg::dcl_out_t result;
  dcl_pkg::dcl_in_t  in_q;
  dcl_pkg::dcl_out_t out_q;
  logic              in_valid_q, out_valid_q;
  logic              advance;

  dcl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The held word moves into the output register when that slot frees up.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  dcl_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .word_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_word_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* hdl/dcl_cfg.sv */
// ----------------------------------------------------------------------------
// Duty cycle limiter configuration
// APB-style register file with clamping and window/budget precomputation.
// ----------------------------------------------------------------------------
module dcl_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output dcl_pkg::dcl_cfg_t cfg_o
);

  logic [15:0] win_sec_q, win_sec_d;
  logic [9:0]  perm_q, perm_d;
  logic [dcl_pkg::MsW-1:0] window_ms_q, window_ms_d;
  logic [dcl_pkg::MsW-1:0] budget_ms_q, budget_ms_d;
  logic        wr_en;
  logic [11:0] sec_clamp;
  logic [9:0]  perm_clamp;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    win_sec_d = win_sec_q;
    perm_d    = perm_q;
    if (wr_en) begin
      unique case (paddr[2])
        dcl_pkg::RegWindowSeconds: win_sec_d = pwdata[15:0];
        dcl_pkg::RegPermille:      perm_d    = pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      dcl_pkg::RegWindowSeconds: prdata = {16'd0, win_sec_q};
      dcl_pkg::RegPermille:      prdata = {22'd0, perm_q};
      default:                   prdata = 32'd0;
    endcase
  end

  // Since the window is seconds * 1000, the budget reduces to seconds * permille.
  always_comb begin
    if (win_sec_q < dcl_pkg::WinSecMin) begin
      sec_clamp = dcl_pkg::WinSecMin[11:0];
    end else if (win_sec_q > dcl_pkg::WinSecMax) begin
      sec_clamp = dcl_pkg::WinSecMax[11:0];
    end else begin
      sec_clamp = win_sec_q[11:0];
    end
    if (perm_q < dcl_pkg::PermMin) begin
      perm_clamp = dcl_pkg::PermMin;
    end else if (perm_q > dcl_pkg::PermMax) begin
      perm_clamp = dcl_pkg::PermMax;
    end else begin
      perm_clamp = perm_q;
    end
    window_ms_d = dcl_pkg::MsW'(sec_clamp) * dcl_pkg::MsW'(dcl_pkg::MsPerSec);
    budget_ms_d = dcl_pkg::MsW'(sec_clamp) * dcl_pkg::MsW'(perm_clamp);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_sec_q   <= dcl_pkg::WinSecReset;
      perm_q      <= dcl_pkg::PermReset;
      window_ms_q <= dcl_pkg::WindowMsReset;
      budget_ms_q <= dcl_pkg::BudgetMsReset;
    end else begin
      win_sec_q   <= win_sec_d;
      perm_q      <= perm_d;
      window_ms_q <= window_ms_d;
      budget_ms_q <= budget_ms_d;
    end
  end

  assign cfg_o.window_ms = window_ms_q;
  assign cfg_o.budget_ms = budget_ms_q;

endmodule

/* hdl/dcl_core.sv */
// ----------------------------------------------------------------------------
// Duty cycle limiter core
// Window and burst tracking state with its single-pass update.
// ----------------------------------------------------------------------------
module dcl_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  dcl_pkg::dcl_in_t  word_i,
  input  dcl_pkg::dcl_cfg_t cfg_i,
  output dcl_pkg::dcl_out_t result_o
);

  logic [31:0] win_start_q, win_start_d;
  logic [31:0] burst_start_q, burst_start_d;
  logic [31:0] used_q, used_d;
  logic        seen_q, seen_d;
  logic        over_q, over_d;

  logic [31:0] window_ms, budget_ms, elapsed, used_a;
  logic        fresh, over_a, seen_a, toggle, rising, falling;

  assign window_ms = {{(32 - dcl_pkg::MsW){1'b0}}, cfg_i.window_ms};
  assign budget_ms = {{(32 - dcl_pkg::MsW){1'b0}}, cfg_i.budget_ms};

  always_comb begin
    elapsed = word_i.now_ms - win_start_q;
    fresh   = (elapsed >= window_ms);

    // A new window carries over any time spent past the budget.
    used_a = used_q;
    over_a = over_q;
    seen_a = seen_q;
    if (fresh) begin
      seen_a = 1'b0;
      if (over_q) begin
        used_a = used_q - budget_ms;
        over_a = (used_a >= budget_ms);
      end else begin
        used_a = 32'd0;
      end
    end

    toggle  = !over_a && (word_i.tx_busy != seen_a);
    rising  = toggle && word_i.tx_busy;
    falling = toggle && !word_i.tx_busy;

    win_start_d   = fresh ? word_i.now_ms : win_start_q;
    burst_start_d = rising ? word_i.now_ms : burst_start_q;
    seen_d        = toggle ? word_i.tx_busy : seen_a;
    used_d        = falling ? used_a + (word_i.now_ms - burst_start_q) : used_a;
    over_d        = over_a | (falling && (used_d >= budget_ms));

    result_o.tx_allowed = !over_d;
    result_o.new_window = fresh;
    result_o.used_ms    = used_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q   <= 32'd0;
      burst_start_q <= 32'd0;
      used_q        <= 32'd0;
      seen_q        <= 1'b0;
      over_q        <= 1'b0;
    end else if (step_i) begin
      win_start_q   <= win_start_d;
      burst_start_q <= burst_start_d;
      used_q        <= used_d;
      seen_q        <= seen_d;
      over_q        <= over_d;
    end
  end

endmodule

/* hdl/dcl_checker.sv */
// ----------------------------------------------------------------------------
// Duty cycle limiter checker
// Port-level assertions on word flow, bound to the top level.
// ----------------------------------------------------------------------------
module dcl_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input dcl_pkg::dcl_out_t out_word_o
);

  logic [1:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Words accepted at the input whose output has not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 2'd0)
    else $error("output word without a matching input word");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("more words in flight than the two register stages hold");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled output");

endmodule

bind tx_duty_cycle_limiter dcl_checker u_dcl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
